FILE: sv/amx_pkg.sv
// Shared types and widths for the affine 3x4 matrix inverse core.
// Used by the interfaces, the intake queue, the sequencer and the divider.
package amx_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int ELEM_W        = 32;
  localparam int NUM_ELEMS     = 12;
  localparam int QUEUE_DEPTH   = 2;
  localparam int MUL_W         = 33;              // signed multiplier operand
  localparam int PROD_W        = 2 * MUL_W;       // multiplier product
  localparam int ADJ_W         = 64;              // adjugate entry, exact
  localparam int DET_W         = 98;              // determinant, exact
  localparam int ACC_W         = 66;              // translation dot product
  localparam int NUM_W         = 128;             // rounded dividend
  localparam int DEN_W         = 98;              // doubled divisor
  localparam int QUO_W         = 32;              // quotient bits
  localparam int NUM_ADJ       = 9;

  localparam logic [ELEM_W-1:0] ELEM_MAX = {1'b0, {(ELEM_W-1){1'b1}}};
  localparam logic [ELEM_W-1:0] ELEM_MIN = {1'b1, {(ELEM_W-1){1'b0}}};

  typedef logic [NUM_ELEMS-1:0][ELEM_W-1:0] mat_t;

  // queue head as seen by the back end
  typedef struct packed {
    logic valid;
    mat_t mat;
  } queue_t;

  // one result row
  typedef struct packed {
    logic [1:0]        row_index;
    logic [ELEM_W-1:0] col0;
    logic [ELEM_W-1:0] col1;
    logic [ELEM_W-1:0] col2;
    logic [ELEM_W-1:0] col3;
    logic              singular;
    logic              last_row;
  } row_t;

endpackage

FILE: sv/amx_if.sv
// Valid/ready channel interfaces for matrix items and result rows.
// Depends on amx_pkg for the element width.
interface amx_in_if;
  import amx_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [ELEM_W-1:0] a00, a01, a02, a03;
  logic signed [ELEM_W-1:0] a10, a11, a12, a13;
  logic signed [ELEM_W-1:0] a20, a21, a22, a23;

  modport source (output valid, a00, a01, a02, a03, a10, a11, a12, a13,
                  a20, a21, a22, a23, input ready);
  modport sink   (input valid, a00, a01, a02, a03, a10, a11, a12, a13,
                  a20, a21, a22, a23, output ready);
endinterface

interface amx_out_if;
  import amx_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [1:0]               row_index;
  logic signed [ELEM_W-1:0] col0, col1, col2, col3;
  logic                     singular;
  logic                     last_row;

  modport source (output valid, row_index, col0, col1, col2, col3, singular, last_row,
                  input ready);
  modport sink   (input valid, row_index, col0, col1, col2, col3, singular, last_row,
                  output ready);
endinterface

FILE: sv/amx_front.sv
// Intake side: accepts matrix items into a two-entry queue.
// Depends on amx_pkg for mat_t and queue_t.
module amx_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  amx_pkg::mat_t  in_mat_i,
  output amx_pkg::queue_t deq_o,
  input  logic           deq_ready_i
);
  import amx_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  mat_t             mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;
  logic             push, pop;

  assign in_ready_o = (count_q != CNT_W'(QUEUE_DEPTH));
  assign push       = in_valid_i && in_ready_o;
  assign deq_o.valid = (count_q != '0);
  assign deq_o.mat   = mem_q[rd_ptr_q];
  assign pop        = deq_o.valid && deq_ready_i;

  // advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
      if (push && !pop)      count_q <= count_q + 1'b1;
      else if (pop && !push) count_q <= count_q - 1'b1;
    end
  end

  // store the item
  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_ptr_q] <= in_mat_i;
  end

endmodule

FILE: sv/amx_div.sv
// Bit-serial rounding divider: adjugate entry * 2^(2F) / determinant,
// rounded half away from zero and saturated to 32 bits. Depends on amx_pkg.
module amx_div #(
  parameter int FRAC_BITS = amx_pkg::FRAC_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic signed [amx_pkg::ADJ_W-1:0] num_i,
  input  logic signed [amx_pkg::DET_W-1:0] den_i,
  output logic                            done_o,
  output logic [amx_pkg::ELEM_W-1:0]      quot_o
);
  import amx_pkg::*;

  localparam logic [1:0] DV_IDLE = 2'd0;
  localparam logic [1:0] DV_CHK  = 2'd1;
  localparam logic [1:0] DV_RUN  = 2'd2;
  localparam int CNT_W = $clog2(QUO_W);

  logic [1:0]        st_q;
  logic [CNT_W-1:0]  cnt_q;
  logic              done_q;
  logic              neg_q;
  logic [NUM_W-1:0]  n_q;
  logic [DEN_W-1:0]  d_q;
  logic [DEN_W-1:0]  r_q;
  logic [QUO_W-1:0]  nlo_q;
  logic [QUO_W-1:0]  q_q;
  logic [ELEM_W-1:0] quot_q;

  logic [ADJ_W-1:0]       an;
  logic [DET_W-1:0]       ad;
  logic [NUM_W-1:0]       n_start;
  logic [DEN_W-1:0]       d_start;
  logic                   ovf;
  logic [DEN_W:0]         trial;
  logic                   ge;
  logic [DEN_W-1:0]       r_next;
  logic [QUO_W-1:0]       q_next;

  function automatic logic [ELEM_W-1:0] sat_quot(input logic neg, input logic big,
                                                 input logic [QUO_W-1:0] q);
    logic [ELEM_W-1:0] res;
    if (big) begin
      res = neg ? ELEM_MIN : ELEM_MAX;
    end else if (neg) begin
      res = (q > QUO_W'(ELEM_MIN)) ? ELEM_MIN : ELEM_W'(QUO_W'(0) - q);
    end else begin
      res = q[QUO_W-1] ? ELEM_MAX : ELEM_W'(q);
    end
    return res;
  endfunction

  // form the rounded dividend 2|n|*2^(2F) + |d| and divisor 2|d|
  always_comb begin
    an      = num_i[ADJ_W-1] ? ADJ_W'(-num_i) : ADJ_W'(num_i);
    ad      = den_i[DET_W-1] ? DET_W'(-den_i) : DET_W'(den_i);
    n_start = (NUM_W'(an) << (2 * FRAC_BITS + 1)) + NUM_W'(ad);
    d_start = DEN_W'(ad) << 1;
    ovf     = (DEN_W + QUO_W)'(n_q) >= {d_q, {QUO_W{1'b0}}};
    trial   = {r_q, nlo_q[QUO_W-1]};
    ge      = trial >= {1'b0, d_q};
    r_next  = ge ? DEN_W'(trial - {1'b0, d_q}) : DEN_W'(trial);
    q_next  = {q_q[QUO_W-2:0], ge};
  end

  // step the sequence
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= DV_IDLE;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (st_q)
        DV_IDLE: begin
          if (start_i) st_q <= DV_CHK;
        end
        DV_CHK: begin
          if (ovf) begin
            st_q   <= DV_IDLE;
            done_q <= 1'b1;
          end else begin
            st_q  <= DV_RUN;
            cnt_q <= CNT_W'(QUO_W - 1);
          end
        end
        DV_RUN: begin
          if (cnt_q == '0) begin
            st_q   <= DV_IDLE;
            done_q <= 1'b1;
          end
          cnt_q <= cnt_q - 1'b1;
        end
        default: st_q <= DV_IDLE;
      endcase
    end
  end

  // hold operands, remainder and quotient
  always_ff @(posedge clk_i) begin
    case (st_q)
      DV_IDLE: begin
        if (start_i) begin
          n_q   <= n_start;
          d_q   <= d_start;
          neg_q <= num_i[ADJ_W-1] ^ den_i[DET_W-1];
        end
      end
      DV_CHK: begin
        r_q    <= DEN_W'(n_q >> QUO_W);
        nlo_q  <= n_q[QUO_W-1:0];
        q_q    <= '0;
        if (ovf) quot_q <= sat_quot(neg_q, 1'b1, '0);
      end
      DV_RUN: begin
        r_q   <= r_next;
        nlo_q <= {nlo_q[QUO_W-2:0], 1'b0};
        q_q   <= q_next;
        if (cnt_q == '0) quot_q <= sat_quot(neg_q, 1'b0, q_next);
      end
      default: ;
    endcase
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

FILE: sv/amx_back.sv
// Execution side: adjugate, determinant, divisions, translation and row output.
// One shared 33x33 multiplier; instantiates amx_div. Depends on amx_pkg.
module amx_back #(
  parameter int FRAC_BITS = amx_pkg::FRAC_BITS_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  amx_pkg::queue_t deq_i,
  output logic            deq_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output amx_pkg::row_t   out_row_o
);
  import amx_pkg::*;

  localparam logic [3:0] B_IDLE  = 4'd0;
  localparam logic [3:0] B_COF   = 4'd1;
  localparam logic [3:0] B_DET   = 4'd2;
  localparam logic [3:0] B_SING  = 4'd3;
  localparam logic [3:0] B_DIV   = 4'd4;
  localparam logic [3:0] B_DWAIT = 4'd5;
  localparam logic [3:0] B_TR    = 4'd6;
  localparam logic [3:0] B_RND   = 4'd7;
  localparam logic [3:0] B_EMIT  = 4'd8;
  localparam int ADJ_IW = $clog2(NUM_ADJ);
  localparam logic [4:0] COF_LAST = 5'd17;
  localparam logic [4:0] DET_LAST = 5'd5;
  localparam logic [4:0] TR_LAST  = 5'd2;
  localparam logic [1:0] ROW_LAST = 2'd2;
  localparam logic [1:0] COL_LAST = 2'd2;

  logic [3:0]               st_q;
  logic [4:0]               idx_q;
  logic                     sub_q;
  logic [1:0]               row_q, col_q;
  logic                     sing_q;
  logic                     out_valid_q;
  mat_t                     m_q;
  logic signed [ADJ_W-1:0]  adj_q [NUM_ADJ];
  logic signed [DET_W-1:0]  det_q;
  logic signed [PROD_W-1:0] tmp_q, prod_q;
  logic [ELEM_W-1:0]        e_q [3];
  logic signed [ACC_W-1:0]  acc_q;
  logic [ACC_W-1:0]         mag_q;
  logic                     rneg_q;
  row_t                     out_q;

  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0] prod_d;
  logic [ADJ_IW-1:0]        adj_rd_idx;
  logic signed [ADJ_W-1:0]  adj_rd;
  logic [ELEM_W-1:0]        e_rd;
  logic signed [DET_W-1:0]  det_term;
  logic [ACC_W-1:0]         acc_abs;
  logic                     load_out;
  logic                     div_done;
  logic [ELEM_W-1:0]        div_quot;

  function automatic logic signed [MUL_W-1:0] sx(input logic [ELEM_W-1:0] e);
    return {e[ELEM_W-1], e};
  endfunction

  function automatic logic [ELEM_W-1:0] sat_mag(input logic neg, input logic [ACC_W-1:0] mag);
    logic [ELEM_W-1:0] res;
    if (neg) begin
      res = (mag > ACC_W'(ELEM_MIN)) ? ELEM_MIN : ELEM_W'(ACC_W'(0) - mag);
    end else begin
      res = (mag > ACC_W'(ELEM_MAX)) ? ELEM_MAX : ELEM_W'(mag);
    end
    return res;
  endfunction

  // select the adjugate entry that the current step reads
  always_comb begin
    case (st_q)
      B_DET: begin
        case (idx_q[2:1])
          2'd0:    adj_rd_idx = ADJ_IW'(0);
          2'd1:    adj_rd_idx = ADJ_IW'(3);
          default: adj_rd_idx = ADJ_IW'(6);
        endcase
      end
      default: adj_rd_idx = ADJ_IW'(row_q) * ADJ_IW'(3) + ADJ_IW'(col_q);
    endcase
  end
  assign adj_rd = adj_q[adj_rd_idx];
  assign e_rd   = e_q[idx_q[1:0]];

  // pick multiplier operands per step
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (st_q)
      B_COF: begin
        case (idx_q)
          5'd0:    begin mul_a = sx(m_q[5]); mul_b = sx(m_q[10]); end
          5'd1:    begin mul_a = sx(m_q[9]); mul_b = sx(m_q[6]);  end
          5'd2:    begin mul_a = sx(m_q[1]); mul_b = sx(m_q[10]); end
          5'd3:    begin mul_a = sx(m_q[9]); mul_b = sx(m_q[2]);  end
          5'd4:    begin mul_a = sx(m_q[1]); mul_b = sx(m_q[6]);  end
          5'd5:    begin mul_a = sx(m_q[5]); mul_b = sx(m_q[2]);  end
          5'd6:    begin mul_a = sx(m_q[4]); mul_b = sx(m_q[10]); end
          5'd7:    begin mul_a = sx(m_q[8]); mul_b = sx(m_q[6]);  end
          5'd8:    begin mul_a = sx(m_q[0]); mul_b = sx(m_q[10]); end
          5'd9:    begin mul_a = sx(m_q[8]); mul_b = sx(m_q[2]);  end
          5'd10:   begin mul_a = sx(m_q[0]); mul_b = sx(m_q[6]);  end
          5'd11:   begin mul_a = sx(m_q[4]); mul_b = sx(m_q[2]);  end
          5'd12:   begin mul_a = sx(m_q[4]); mul_b = sx(m_q[9]);  end
          5'd13:   begin mul_a = sx(m_q[8]); mul_b = sx(m_q[5]);  end
          5'd14:   begin mul_a = sx(m_q[0]); mul_b = sx(m_q[9]);  end
          5'd15:   begin mul_a = sx(m_q[8]); mul_b = sx(m_q[1]);  end
          5'd16:   begin mul_a = sx(m_q[0]); mul_b = sx(m_q[5]);  end
          5'd17:   begin mul_a = sx(m_q[4]); mul_b = sx(m_q[1]);  end
          default: ;
        endcase
      end
      B_DET: begin
        case (idx_q[2:1])
          2'd0:    mul_a = sx(m_q[0]);
          2'd1:    mul_a = sx(m_q[1]);
          default: mul_a = sx(m_q[2]);
        endcase
        mul_b = idx_q[0] ? {1'b0, adj_rd[ELEM_W-1:0]} : {adj_rd[ADJ_W-1], adj_rd[ADJ_W-1:ELEM_W]};
      end
      B_TR: begin
        mul_a = sx(e_rd);
        case (idx_q[1:0])
          2'd0:    mul_b = sx(m_q[3]);
          2'd1:    mul_b = sx(m_q[7]);
          default: mul_b = sx(m_q[11]);
        endcase
      end
      default: ;
    endcase
  end

  assign prod_d   = mul_a * mul_b;
  assign det_term = idx_q[0] ? DET_W'(prod_q) : (DET_W'(prod_q) <<< ELEM_W);
  assign acc_abs  = acc_q[ACC_W-1] ? ACC_W'(-acc_q) : ACC_W'(acc_q);
  assign load_out = (st_q == B_EMIT) && (!out_valid_q || out_ready_i);
  assign deq_ready_o = (st_q == B_IDLE);

  amx_div #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (st_q == B_DIV),
    .num_i   (adj_rd),
    .den_i   (det_q),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  // advance the sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= B_IDLE;
      idx_q       <= '0;
      sub_q       <= 1'b0;
      row_q       <= '0;
      col_q       <= '0;
      sing_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (load_out)         out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
      case (st_q)
        B_IDLE: begin
          if (deq_i.valid) begin
            st_q  <= B_COF;
            idx_q <= '0;
            sub_q <= 1'b0;
          end
        end
        B_COF: begin
          sub_q <= ~sub_q;
          if (sub_q) begin
            if (idx_q == COF_LAST) begin
              st_q  <= B_DET;
              idx_q <= '0;
            end else begin
              idx_q <= idx_q + 1'b1;
            end
          end
        end
        B_DET: begin
          sub_q <= ~sub_q;
          if (sub_q) begin
            if (idx_q == DET_LAST) st_q <= B_SING;
            else                   idx_q <= idx_q + 1'b1;
          end
        end
        B_SING: begin
          sing_q <= (det_q == '0);
          row_q  <= '0;
          col_q  <= '0;
          st_q   <= (det_q == '0) ? B_EMIT : B_DIV;
        end
        B_DIV: st_q <= B_DWAIT;
        B_DWAIT: begin
          if (div_done) begin
            if (col_q == COL_LAST) begin
              st_q  <= B_TR;
              idx_q <= '0;
              sub_q <= 1'b0;
            end else begin
              col_q <= col_q + 1'b1;
              st_q  <= B_DIV;
            end
          end
        end
        B_TR: begin
          sub_q <= ~sub_q;
          if (sub_q) begin
            if (idx_q == TR_LAST) st_q <= B_RND;
            else                  idx_q <= idx_q + 1'b1;
          end
        end
        B_RND: st_q <= B_EMIT;
        B_EMIT: begin
          if (load_out) begin
            if (row_q == ROW_LAST) begin
              st_q <= B_IDLE;
            end else begin
              row_q <= row_q + 1'b1;
              col_q <= '0;
              st_q  <= sing_q ? B_EMIT : B_DIV;
            end
          end
        end
        default: st_q <= B_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    if (st_q == B_IDLE && deq_i.valid) m_q <= deq_i.mat;
    if (st_q == B_COF && sub_q) begin
      if (!idx_q[0]) tmp_q <= prod_q;
      else if (idx_q[1]) adj_q[idx_q[4:1]] <= ADJ_W'(prod_q - tmp_q);
      else               adj_q[idx_q[4:1]] <= ADJ_W'(tmp_q - prod_q);
    end
    if (st_q == B_DET && sub_q) begin
      det_q <= ((idx_q == '0) ? DET_W'(0) : det_q) + det_term;
    end
    if (st_q == B_DWAIT && div_done) e_q[col_q] <= div_quot;
    if (st_q == B_TR && sub_q) begin
      acc_q <= ((idx_q == '0) ? ACC_W'(0) : acc_q) + ACC_W'(prod_q);
    end
    // negated sum: result is negative when the sum is positive
    if (st_q == B_RND) begin
      rneg_q <= !acc_q[ACC_W-1] && (acc_q != '0);
      mag_q  <= (acc_abs + (ACC_W'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
    end
    if (load_out) begin
      out_q.row_index <= row_q;
      out_q.col0      <= sing_q ? '0 : e_q[0];
      out_q.col1      <= sing_q ? '0 : e_q[1];
      out_q.col2      <= sing_q ? '0 : e_q[2];
      out_q.col3      <= sing_q ? '0 : sat_mag(rneg_q, mag_q);
      out_q.singular  <= sing_q;
      out_q.last_row  <= (row_q == ROW_LAST);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_row_o   = out_q;

endmodule

FILE: sv/affine_matrix_inverse_core.sv
// Affine 3x4 matrix inverse, Q(32-F).F in and out, three result rows per matrix.
// Throughput is set by the one shared 33x33 multiplier and the bit-serial divider,
// and is higher for a singular matrix, which skips the divisions and the translation.
// A two-entry queue takes new matrices while one is being inverted.
// Asynchronous active-low reset empties the queue and returns the sequencer to idle.
// Depends on amx_pkg.
module affine_matrix_inverse_core #(
  parameter int FRAC_BITS = amx_pkg::FRAC_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  amx_in_if.sink    in_i,
  amx_out_if.source out_o
);
  import amx_pkg::*;

  mat_t   in_mat;
  queue_t deq;
  logic   deq_ready;
  row_t   out_row;
  logic   in_ready;
  logic   out_valid;

  // pack the matrix, row-major
  assign in_mat = {in_i.a23, in_i.a22, in_i.a21, in_i.a20,
                   in_i.a13, in_i.a12, in_i.a11, in_i.a10,
                   in_i.a03, in_i.a02, in_i.a01, in_i.a00};
  assign in_i.ready = in_ready;

  amx_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_ready),
    .in_mat_i    (in_mat),
    .deq_o       (deq),
    .deq_ready_i (deq_ready)
  );

  amx_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .deq_i       (deq),
    .deq_ready_o (deq_ready),
    .out_valid_o (out_valid),
    .out_ready_i (out_o.ready),
    .out_row_o   (out_row)
  );

  // drive the result channel
  assign out_o.valid     = out_valid;
  assign out_o.row_index = out_row.row_index;
  assign out_o.col0      = out_row.col0;
  assign out_o.col1      = out_row.col1;
  assign out_o.col2      = out_row.col2;
  assign out_o.col3      = out_row.col3;
  assign out_o.singular  = out_row.singular;
  assign out_o.last_row  = out_row.last_row;

endmodule
